FILE: hw/rtl/dsrs_pkg.sv
// ----------------------------------------------------------------------------
// dsrs_pkg
// Shared types, constants and CRC-32 helpers for the dual slot record selector.
// ----------------------------------------------------------------------------
package dsrs_pkg;

    localparam logic [31:0] REC_MAGIC   = 32'h4655_534E;
    localparam logic [31:0] REC_VERSION = 32'd2;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [15:0] NODE_LIMIT  = 16'h07FF;
    localparam int          CRC_BITS    = 128;

    localparam logic [1:0] CFG_MAX_MODE     = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_MODE = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_NODE = 2'd2;

    typedef logic [CRC_BITS-1:0][31:0] t_crc_cols;

    typedef struct packed {
        logic [7:0]  max_mode;
        logic [7:0]  default_mode;
        logic [10:0] default_node;
    } t_cfg;

    typedef struct packed {
        logic        ok;
        logic [31:0] seq;
        logic [7:0]  mode;
        logic [10:0] node;
    } t_rec_chk;

    typedef struct packed {
        logic        status;
        logic        chosen_slot;
        logic [7:0]  mode;
        logic [10:0] node;
        logic        item_valid;
    } t_result;

    // one reflected CRC step on one stream bit
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic b);
        logic fb;
        fb = c[0] ^ b;
        return (c >> 1) ^ (fb ? CRC_POLY : 32'h0);
    endfunction

    // contribution of each stream bit to the final CRC, zero start value
    function automatic t_crc_cols crc_columns();
        t_crc_cols   cols;
        logic [31:0] c;
        for (int p = 0; p < CRC_BITS; p++) begin
            c = CRC_POLY;
            for (int s = p + 1; s < CRC_BITS; s++) begin
                c = crc_step(c, 1'b0);
            end
            cols[p] = c;
        end
        return cols;
    endfunction

    // CRC of an all-zero stream from the all-ones start value
    function automatic logic [31:0] crc_zero_init();
        logic [31:0] c;
        c = CRC_INIT;
        for (int s = 0; s < CRC_BITS; s++) begin
            c = crc_step(c, 1'b0);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/dsrs_check.sv
// ----------------------------------------------------------------------------
// dsrs_check
// Record check: CRC-32 over the 16 record bytes as an XOR of constant
// columns, plus the marker, version, mode and node id range checks.
// ----------------------------------------------------------------------------
module dsrs_check
    import dsrs_pkg::*;
(
    input  logic [31:0] i_magic_word,
    input  logic [31:0] i_format_version,
    input  logic [31:0] i_sequence_number,
    input  logic [7:0]  i_mode_byte,
    input  logic [7:0]  i_reserved_byte,
    input  logic [15:0] i_node_word,
    input  logic [31:0] i_stored_crc,
    input  logic [7:0]  i_max_mode,
    output t_rec_chk    o_chk
);

    localparam t_crc_cols   CRC_COLS = crc_columns();
    localparam logic [31:0] CRC_BASE = crc_zero_init();

    logic [CRC_BITS-1:0] stream;
    logic [31:0]         crc;

    assign stream = {i_node_word, i_reserved_byte, i_mode_byte,
                     i_sequence_number, i_format_version, i_magic_word};

    always_comb begin
        crc = CRC_BASE;
        for (int p = 0; p < CRC_BITS; p++) begin
            crc = crc ^ (stream[p] ? CRC_COLS[p] : 32'h0);
        end
    end

    always_comb begin
        o_chk.ok   = (i_magic_word == REC_MAGIC) && (i_format_version == REC_VERSION) &&
                     (i_mode_byte <= i_max_mode) && (i_node_word <= NODE_LIMIT) &&
                     (i_stored_crc == crc);
        o_chk.seq  = i_sequence_number;
        o_chk.mode = i_mode_byte;
        o_chk.node = i_node_word[10:0];
    end

endmodule

FILE: hw/rtl/dsrs_select.sv
// ----------------------------------------------------------------------------
// dsrs_select
// Slot 0 record store, slot selection by serial sequence compare, and the
// result register.
// ----------------------------------------------------------------------------
module dsrs_select
    import dsrs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s1_valid,
    input  logic     i_s1_slot,
    input  t_rec_chk i_chk,
    input  t_cfg     i_cfg,
    input  logic     i_out_ready,
    output logic     o_s1_take,
    output logic     o_out_valid,
    output t_result  o_result
);

    logic        r_first_valid;
    logic [31:0] r_first_seq;
    logic [7:0]  r_first_mode;
    logic [10:0] r_first_node;
    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;
    logic [31:0] diff;
    logic        zero_newer;
    logic        out_free;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_s1_take = i_s1_valid && (!i_s1_slot || out_free);

    assign diff       = r_first_seq - i_chk.seq;
    assign zero_newer = (diff != 32'h0) && !diff[31];

    always_comb begin
        n_result.item_valid = i_chk.ok;
        if (r_first_valid && (!i_chk.ok || zero_newer)) begin
            n_result.status      = 1'b0;
            n_result.chosen_slot = 1'b0;
            n_result.mode        = r_first_mode;
            n_result.node        = r_first_node;
        end else if (i_chk.ok) begin
            n_result.status      = 1'b0;
            n_result.chosen_slot = 1'b1;
            n_result.mode        = i_chk.mode;
            n_result.node        = i_chk.node;
        end else begin
            n_result.status      = 1'b1;
            n_result.chosen_slot = 1'b1;
            n_result.mode        = i_cfg.default_mode;
            n_result.node        = i_cfg.default_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_s1_take && !i_s1_slot) begin
                r_first_valid <= i_chk.ok;
            end
            if (o_s1_take && i_s1_slot) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take && !i_s1_slot) begin
            r_first_seq  <= i_chk.seq;
            r_first_mode <= i_chk.mode;
            r_first_node <= i_chk.node;
        end
        if (o_s1_take && i_s1_slot) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

FILE: hw/rtl/dual_slot_record_selector.sv
// ----------------------------------------------------------------------------
// dual_slot_record_selector
// Checks settings records from two storage slots and reports the chosen one.
// ----------------------------------------------------------------------------
// Each item is one record tagged slot 0 or slot 1. A slot 0 item is stored
// and gives no result; a slot 1 item gives one result choosing between the
// stored slot 0 record, itself, or the configured defaults. Items pass an
// input register and a result register: one item per cycle is accepted, and
// each slot 1 item's result is registered as it leaves the input register.
// A slot 1 item waits in the input register, and holds off the next item,
// only while an earlier result is stalled at the output. The CRC-32 over
// the 16 record bytes is a single XOR network between those two registers.
// Configuration must be written by the user only while no item is in flight.
// ----------------------------------------------------------------------------
module dual_slot_record_selector
    import dsrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_slot,
    input  logic [31:0] i_magic_word,
    input  logic [31:0] i_format_version,
    input  logic [31:0] i_sequence_number,
    input  logic [7:0]  i_mode_byte,
    input  logic [7:0]  i_reserved_byte,
    input  logic [15:0] i_node_word,
    input  logic [31:0] i_stored_crc,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic        o_chosen_slot,
    output logic [7:0]  o_mode_out,
    output logic [10:0] o_node_id_out,
    output logic        o_item_valid
);

    t_cfg        r_cfg;
    logic        r_s1_valid;
    logic        r_slot;
    logic [31:0] r_magic_word;
    logic [31:0] r_format_version;
    logic [31:0] r_sequence_number;
    logic [7:0]  r_mode_byte;
    logic [7:0]  r_reserved_byte;
    logic [15:0] r_node_word;
    logic [31:0] r_stored_crc;
    logic        s1_take;
    t_rec_chk    chk;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_mode     <= 8'd2;
            r_cfg.default_mode <= 8'd1;
            r_cfg.default_node <= 11'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_MODE:     r_cfg.max_mode     <= i_cfg_data[7:0];
                CFG_DEFAULT_MODE: r_cfg.default_mode <= i_cfg_data[7:0];
                CFG_DEFAULT_NODE: r_cfg.default_node <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_s1_valid || s1_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_slot            <= i_slot;
            r_magic_word      <= i_magic_word;
            r_format_version  <= i_format_version;
            r_sequence_number <= i_sequence_number;
            r_mode_byte       <= i_mode_byte;
            r_reserved_byte   <= i_reserved_byte;
            r_node_word       <= i_node_word;
            r_stored_crc      <= i_stored_crc;
        end
    end

    dsrs_check u_check (
        .i_magic_word      (r_magic_word),
        .i_format_version  (r_format_version),
        .i_sequence_number (r_sequence_number),
        .i_mode_byte       (r_mode_byte),
        .i_reserved_byte   (r_reserved_byte),
        .i_node_word       (r_node_word),
        .i_stored_crc      (r_stored_crc),
        .i_max_mode        (r_cfg.max_mode),
        .o_chk             (chk)
    );

    dsrs_select u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (r_s1_valid),
        .i_s1_slot   (r_slot),
        .i_chk       (chk),
        .i_cfg       (r_cfg),
        .i_out_ready (i_out_ready),
        .o_s1_take   (s1_take),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_status      = result.status;
    assign o_chosen_slot = result.chosen_slot;
    assign o_mode_out    = result.mode;
    assign o_node_id_out = result.node;
    assign o_item_valid  = result.item_valid;

endmodule

FILE: hw/rtl/dsrs_checker.sv
// ----------------------------------------------------------------------------
// dsrs_checker
// Port-level checks on the result channel of the dual slot record selector.
// ----------------------------------------------------------------------------
module dsrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_status,
    input logic        o_chosen_slot,
    input logic [7:0]  o_mode_out,
    input logic [10:0] o_node_id_out,
    input logic        o_item_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
        $stable(o_chosen_slot) && $stable(o_mode_out) && $stable(o_node_id_out) &&
        $stable(o_item_valid))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_default_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_chosen_slot && !o_item_valid)
        else $error("defaults given with a chosen record");

    a_slot1_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status && o_chosen_slot |-> o_item_valid)
        else $error("invalid slot 1 record chosen");

endmodule

bind dual_slot_record_selector dsrs_checker u_dsrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_chosen_slot (o_chosen_slot),
    .o_mode_out    (o_mode_out),
    .o_node_id_out (o_node_id_out),
    .o_item_valid  (o_item_valid)
);
